/* rtl/core/cfws_pkg.sv */
// Shared constants, codes and helper functions for the searchable ring FIFO.
package cfws_pkg;

    // Ring storage geometry
    localparam int DEPTH  = 16;
    localparam int SLOT_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int WORD_W = 32;
    localparam int CFG_W  = 5;
    localparam int CMD_W  = 2;
    localparam int STAT_W = 2;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_ENQ  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DEQ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SRCH = 2'd2;

    // Status codes
    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd2;
    localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd3;

    // Error word returned by failed commands
    localparam logic [WORD_W-1:0] ERR_WORD = '1;

    // Capacity after reset
    localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(DEPTH);

    // Clamp the programmed capacity into 1..DEPTH
    function automatic logic [CNT_W-1:0] eff_cap(input logic [CFG_W-1:0] cap);
        logic [CNT_W-1:0] c;
        begin
            if (cap == '0)
                c = CNT_W'(1);
            else if (32'(cap) > 32'(DEPTH))
                c = CNT_W'(DEPTH);
            else
                c = CNT_W'(cap);
            return c;
        end
    endfunction

    // Advance a ring pointer, wrapping at the effective capacity
    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] i,
                                                    input logic [CNT_W-1:0]  cap);
        logic [CNT_W:0] n;
        begin
            n = (CNT_W+1)'(i) + (CNT_W+1)'(1);
            if (n >= (CNT_W+1)'(cap) || n >= (CNT_W+1)'(DEPTH))
                return '0;
            else
                return n[SLOT_W-1:0];
        end
    endfunction

endpackage

/* rtl/core/cfws_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module cfws_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/circular_fifo_with_search.sv */
// Top level of the ring FIFO with enqueue, dequeue and linear search commands.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-----------------------------------
//   in      | input     | in_valid / in_ready   | cmd, value
//   out     | output    | out_valid / out_ready | status, data, count, is_full, is_empty
//   cfg     | input     | cfg_valid / cfg_ready | cfg_data (capacity in use)
//
// Enqueue and failed commands finish in the accept cycle; dequeue passes through
// the S_DEQ state because the slot RAM has a registered read port.
// Search streams one slot per cycle through the RAM read port in the S_SCAN state,
// stopping at the first match or after the last held entry.
// Reset clears pointers, count and output valid, restores capacity; slots keep their data.
// A stalled output holds its word; the next item is still accepted and its result
// parks in a pending register until the output frees.
module circular_fifo_with_search (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [cfws_pkg::CMD_W-1:0]           cmd,
    input  logic signed [cfws_pkg::WORD_W-1:0]   value,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [cfws_pkg::STAT_W-1:0]          status,
    output logic signed [cfws_pkg::WORD_W-1:0]   data,
    output logic [cfws_pkg::CNT_W-1:0]           count,
    output logic                                 is_full,
    output logic                                 is_empty,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [cfws_pkg::CFG_W-1:0]           cfg_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DEQ  = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_HOLD = 2'd3;

    logic [1:0]                      state_reg, state_next;
    logic [cfws_pkg::SLOT_W-1:0]     head_reg, head_next;
    logic [cfws_pkg::SLOT_W-1:0]     tail_reg, tail_next;
    logic [cfws_pkg::CNT_W-1:0]      count_reg, count_next;
    logic [cfws_pkg::CFG_W-1:0]      cap_reg;
    logic [cfws_pkg::CNT_W-1:0]      cap;
    logic [cfws_pkg::WORD_W-1:0]     key_reg, key_next;
    logic [cfws_pkg::SLOT_W-1:0]     scan_slot_reg, scan_slot_next;
    logic [cfws_pkg::CNT_W-1:0]      scan_pos_reg, scan_pos_next;

    // Result produced this cycle
    logic                            res_valid;
    logic [cfws_pkg::STAT_W-1:0]     res_status;
    logic [cfws_pkg::WORD_W-1:0]     res_data;
    logic [cfws_pkg::CNT_W-1:0]      res_count;

    // Pending result waiting for the output register
    logic [cfws_pkg::STAT_W-1:0]     pend_status_reg;
    logic [cfws_pkg::WORD_W-1:0]     pend_data_reg;
    logic [cfws_pkg::CNT_W-1:0]      pend_count_reg;

    // Output register
    logic                            out_valid_reg;
    logic [cfws_pkg::STAT_W-1:0]     out_status_reg;
    logic [cfws_pkg::WORD_W-1:0]     out_data_reg;
    logic [cfws_pkg::CNT_W-1:0]      out_count_reg;
    logic                            out_full_reg;
    logic                            out_empty_reg;

    logic                            in_fire;
    logic                            out_free;
    logic                            load_res;
    logic                            load_pend;
    logic                            save_pend;

    // RAM ports
    logic                            ram_we;
    logic [cfws_pkg::SLOT_W-1:0]     ram_waddr;
    logic [cfws_pkg::SLOT_W-1:0]     ram_raddr;
    logic [cfws_pkg::WORD_W-1:0]     ram_rdata;
    logic [cfws_pkg::SLOT_W-1:0]     scan_adv;

    cfws_ram #(
        .WIDTH (cfws_pkg::WORD_W),
        .DEPTH (cfws_pkg::DEPTH)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cap       = cfws_pkg::eff_cap(cap_reg);
    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign cfg_ready = 1'b1;
    assign scan_adv  = cfws_pkg::next_slot(scan_slot_reg, cap);

    // Sequence commands: read, modify and write back ring state
    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        key_next       = key_reg;
        scan_slot_next = scan_slot_reg;
        scan_pos_next  = scan_pos_reg;
        ram_we         = 1'b0;
        ram_waddr      = tail_reg;
        ram_raddr      = head_reg;
        res_valid      = 1'b0;
        res_status     = cfws_pkg::STAT_OK;
        res_data       = cfws_pkg::WORD_W'(count_reg);
        res_count      = count_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    case (cmd)
                        cfws_pkg::CMD_ENQ:
                        begin
                            res_valid = 1'b1;
                            if (count_reg >= cap)
                            begin
                                res_status = cfws_pkg::STAT_FULL;
                                res_data   = cfws_pkg::ERR_WORD;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                tail_next  = cfws_pkg::next_slot(tail_reg, cap);
                                count_next = count_reg + cfws_pkg::CNT_W'(1);
                                res_data   = cfws_pkg::WORD_W'(count_next);
                                res_count  = count_next;
                            end
                        end
                        cfws_pkg::CMD_DEQ:
                        begin
                            if (count_reg == '0)
                            begin
                                res_valid  = 1'b1;
                                res_status = cfws_pkg::STAT_EMPTY;
                                res_data   = cfws_pkg::ERR_WORD;
                            end
                            else
                            begin
                                // head word arrives from the RAM next cycle
                                head_next  = cfws_pkg::next_slot(head_reg, cap);
                                count_next = count_reg - cfws_pkg::CNT_W'(1);
                                state_next = S_DEQ;
                            end
                        end
                        cfws_pkg::CMD_SRCH:
                        begin
                            if (count_reg == '0)
                            begin
                                res_valid  = 1'b1;
                                res_status = cfws_pkg::STAT_NOTFOUND;
                                res_data   = cfws_pkg::ERR_WORD;
                            end
                            else
                            begin
                                key_next       = value;
                                scan_slot_next = head_reg;
                                scan_pos_next  = '0;
                                state_next     = S_SCAN;
                            end
                        end
                        default:
                        begin
                            res_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_DEQ:
            begin
                res_valid = 1'b1;
                res_data  = ram_rdata;
            end
            S_SCAN:
            begin
                // compare the word read last cycle, fetch the next slot
                ram_raddr = scan_adv;
                if (ram_rdata == key_reg)
                begin
                    res_valid = 1'b1;
                    res_data  = cfws_pkg::WORD_W'(scan_pos_reg);
                end
                else if (scan_pos_reg + cfws_pkg::CNT_W'(1) == count_reg)
                begin
                    res_valid  = 1'b1;
                    res_status = cfws_pkg::STAT_NOTFOUND;
                    res_data   = cfws_pkg::ERR_WORD;
                end
                else
                begin
                    scan_slot_next = scan_adv;
                    scan_pos_next  = scan_pos_reg + cfws_pkg::CNT_W'(1);
                end
            end
            S_HOLD:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Park the result when the output register is busy
        if (res_valid)
            state_next = out_free ? S_IDLE : S_HOLD;
    end

    assign load_res  = res_valid && out_free;
    assign save_pend = res_valid && !out_free;
    assign load_pend = (state_reg == S_HOLD) && out_free;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            cap_reg       <= cfws_pkg::CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            if (cfg_valid && cfg_ready)
                cap_reg <= cfg_data;
            if (load_res || load_pend)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        key_reg       <= key_next;
        scan_slot_reg <= scan_slot_next;
        scan_pos_reg  <= scan_pos_next;
        if (save_pend)
        begin
            pend_status_reg <= res_status;
            pend_data_reg   <= res_data;
            pend_count_reg  <= res_count;
        end
        if (load_res)
        begin
            out_status_reg <= res_status;
            out_data_reg   <= res_data;
            out_count_reg  <= res_count;
            out_full_reg   <= (res_count >= cap);
            out_empty_reg  <= (res_count == '0);
        end
        else if (load_pend)
        begin
            out_status_reg <= pend_status_reg;
            out_data_reg   <= pend_data_reg;
            out_count_reg  <= pend_count_reg;
            out_full_reg   <= (pend_count_reg >= cap);
            out_empty_reg  <= (pend_count_reg == '0);
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign data      = out_data_reg;
    assign count     = out_count_reg;
    assign is_full   = out_full_reg;
    assign is_empty  = out_empty_reg;

    // A parked result always has a busy output register in front of it
    a_hold_needs_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_HOLD) |-> out_valid_reg)
        else $error("pending result without a busy output register");

    // A scan never runs past the held entries
    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (scan_pos_reg < count_reg))
        else $error("search position beyond entry count");

    // A successful enqueue grows the count by one
    a_enq_count: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && cmd == cfws_pkg::CMD_ENQ && count_reg < cap)
        |=> (count_reg == $past(count_reg) + cfws_pkg::CNT_W'(1)))
        else $error("enqueue did not advance the count");

    // A dequeue of a non-empty ring moves to S_DEQ to wait for the RAM word
    a_deq_read: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && cmd == cfws_pkg::CMD_DEQ && count_reg != '0)
        |=> (state_reg == S_DEQ))
        else $error("dequeue skipped the RAM read cycle");

endmodule

/* sim/circular_fifo_with_search_checker.sv */
// Reply checker for the searchable ring FIFO: mirrors the ring and compares every reply word.
module circular_fifo_with_search_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic                                 in_ready,
    input  logic [cfws_pkg::CMD_W-1:0]           cmd,
    input  logic signed [cfws_pkg::WORD_W-1:0]   value,
    input  logic                                 out_valid,
    input  logic                                 out_ready,
    input  logic [cfws_pkg::STAT_W-1:0]          status,
    input  logic signed [cfws_pkg::WORD_W-1:0]   data,
    input  logic [cfws_pkg::CNT_W-1:0]           count,
    input  logic                                 is_full,
    input  logic                                 is_empty,
    input  logic                                 cfg_valid,
    input  logic                                 cfg_ready,
    input  logic [cfws_pkg::CFG_W-1:0]           cfg_data,
    output int                                   mismatches,
    output int                                   pending
);
    import cfws_pkg::*;

    typedef struct {
        logic [STAT_W-1:0] status;
        logic [WORD_W-1:0] data;
        logic [CNT_W-1:0]  count;
        logic              is_full;
        logic              is_empty;
    } reply_t;

    // Shadow copy of the ring and its pointers
    logic [WORD_W-1:0] ring_words [DEPTH];
    logic [SLOT_W-1:0] head_idx;
    logic [SLOT_W-1:0] tail_idx;
    logic [CNT_W-1:0]  held;
    logic [CFG_W-1:0]  capacity_reg;

    reply_t expected_replies [$];
    int     fail_total;

    // Zero acts as one slot, anything above the ring size acts as the full ring
    function automatic int clamp_capacity();
        int c;
        c = int'(capacity_reg);
        if (c == 0)
            c = 1;
        if (c > DEPTH)
            c = DEPTH;
        return c;
    endfunction

    // Step a ring pointer, wrapping at the capacity or at the end of storage
    function automatic logic [SLOT_W-1:0] ring_advance(input logic [SLOT_W-1:0] idx,
                                                      input int cap);
        int n;
        n = int'(idx) + 1;
        if (n >= cap || n >= DEPTH)
            return '0;
        return SLOT_W'(n);
    endfunction

    // Apply one command to the shadow ring and return the reply it must produce
    function automatic reply_t apply_fifo_command(input logic [CMD_W-1:0]  op,
                                                  input logic [WORD_W-1:0] word);
        reply_t            r;
        int                cap;
        logic [SLOT_W-1:0] idx;
        logic              found;
        cap = clamp_capacity();
        r.status = STAT_OK;
        r.data = '0;
        case (op)
            CMD_ENQ:
            begin
                if (held >= cap) begin
                    r.status = STAT_FULL;
                    r.data = ERR_WORD;
                end else begin
                    ring_words[tail_idx] = word;
                    tail_idx = ring_advance(tail_idx, cap);
                    held = held + 1'b1;
                    r.data = WORD_W'(held);
                end
            end
            CMD_DEQ:
            begin
                if (held == 0) begin
                    r.status = STAT_EMPTY;
                    r.data = ERR_WORD;
                end else begin
                    r.data = ring_words[head_idx];
                    head_idx = ring_advance(head_idx, cap);
                    held = held - 1'b1;
                end
            end
            CMD_SRCH:
            begin
                // Scan from the head; keep the first match only
                r.status = STAT_NOTFOUND;
                r.data = ERR_WORD;
                idx = head_idx;
                found = 1'b0;
                for (int k = 0; k < int'(held); k++) begin
                    if (!found && ring_words[idx] == word) begin
                        found = 1'b1;
                        r.status = STAT_OK;
                        r.data = WORD_W'(k);
                    end
                    idx = ring_advance(idx, cap);
                end
            end
            default:
            begin
                // Unused code: no change, report the count
                r.data = WORD_W'(held);
            end
        endcase
        r.count = held;
        r.is_full = (held >= cap);
        r.is_empty = (held == 0);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
        if (want !== got) begin
            fail_total++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    // Track configuration, predict on accepted commands, compare on accepted replies
    always @(posedge clk or negedge rst_n) begin : track
        reply_t want;
        if (!rst_n) begin
            for (int i = 0; i < DEPTH; i++)
                ring_words[i] = '0;
            head_idx = '0;
            tail_idx = '0;
            held = '0;
            capacity_reg = CAP_RESET;
            expected_replies.delete();
            fail_total = 0;
            pending <= 0;
            mismatches <= 0;
        end else begin
            if (cfg_valid && cfg_ready)
                capacity_reg = cfg_data;
            if (out_valid && out_ready) begin
                if (expected_replies.size() == 0) begin
                    fail_total++;
                    $display("%0t: reply word with nothing expected, expected none actual %0h/%0h",
                             $time, status, data);
                end else begin
                    want = expected_replies.pop_front();
                    check_field("status", WORD_W'(want.status), WORD_W'(status));
                    check_field("data", want.data, data);
                    check_field("count", WORD_W'(want.count), WORD_W'(count));
                    check_field("is_full", WORD_W'(want.is_full), WORD_W'(is_full));
                    check_field("is_empty", WORD_W'(want.is_empty), WORD_W'(is_empty));
                end
            end
            if (in_valid && in_ready)
                expected_replies.push_back(apply_fifo_command(cmd, value));
            pending <= expected_replies.size();
            mismatches <= fail_total;
        end
    end

endmodule

/* sim/circular_fifo_with_search_tb.sv */
// Testbench top for the searchable ring FIFO: clock, reset, stimulus, watchdog and verdict.
module circular_fifo_with_search_tb;
    import cfws_pkg::*;

    localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;
    localparam int IDLE_LIMIT    = 1000;
    localparam int PHASE_ITEMS   = 120;
    localparam int SETTLE_CYCLES = 20;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [CMD_W-1:0]     cmd;
    logic signed [WORD_W-1:0] value;
    logic                 out_valid;
    logic                 out_ready;
    logic [STAT_W-1:0]    status;
    logic signed [WORD_W-1:0] data;
    logic [CNT_W-1:0]     count;
    logic                 is_full;
    logic                 is_empty;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_W-1:0]     cfg_data;

    int mismatches;
    int pending;
    int idle_cycles = 0;
    int cmd_tally [4];
    int cap_settings;
    bit send_burst;
    bit take_burst;

    // Capacity settings per phase: extremes, out-of-range codes and a few in between
    logic [CFG_W-1:0] capacity_plan [10] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd5,
                                            5'd17, 5'd2, 5'd16, 5'd9, 5'd3};

    // 20-unit clock
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    circular_fifo_with_search u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .data      (data),
        .count     (count),
        .is_full   (is_full),
        .is_empty  (is_empty),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    circular_fifo_with_search_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .value      (value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .data       (data),
        .count      (count),
        .is_full    (is_full),
        .is_empty   (is_empty),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    // Pick a word: half the time from a small pool so searches hit, sometimes extremes or anything
    function automatic logic [WORD_W-1:0] pick_word();
        logic [WORD_W-1:0] w;
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 3))
                    0: w = 32'h8000_0000;
                    1: w = 32'h7fff_ffff;
                    2: w = '1;
                    default: w = '0;
                endcase
            end
            1, 2, 3, 4, 5: w = WORD_W'($urandom_range(0, 7));
            default: w = $urandom;
        endcase
        return w;
    endfunction

    // Lean toward enqueue while filling and toward dequeue while draining
    function automatic logic [CMD_W-1:0] pick_command(input bit filling);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return CMD_NOP;
        if (r < 28)
            return CMD_SRCH;
        if (filling)
            return (r < 78) ? CMD_ENQ : CMD_DEQ;
        return (r < 50) ? CMD_ENQ : CMD_DEQ;
    endfunction

    // Offer one command word after a random gap and hold it until accepted
    task automatic send_command(input logic [CMD_W-1:0] op, input logic [WORD_W-1:0] word);
        int gap;
        if ($urandom_range(0, 19) == 0)
            send_burst = !send_burst;
        gap = send_burst ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= op;
        value <= word;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        cmd_tally[op]++;
    endtask

    // Drop valid and hold off until every expected reply has come back
    task automatic drain_replies();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Write the capacity register; only called with no reply outstanding
    task automatic write_capacity(input logic [CFG_W-1:0] cap);
        cfg_valid <= 1'b1;
        cfg_data <= cap;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        cap_settings++;
    endtask

    // Reply side: stall for a random gap before each word, with stretches of no stall
    initial begin : reply_sink
        int hold;
        out_ready = 1'b0;
        take_burst = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if ($urandom_range(0, 19) == 0)
                take_burst = !take_burst;
            hold = take_burst ? 0 : $urandom_range(0, 5);
            if (hold > 0) begin
                out_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!(out_valid && out_ready))
                @(posedge clk);
        end
    end

    // Stop the run when no word moves on any channel for too long
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: watchdog, no word moved for %0d cycles", $time, IDLE_LIMIT);
                $display("circular_fifo_with_search test failed");
                $finish;
            end else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        bit filling;
        int run_left;
        rst_n = 1'b0;
        in_valid = 1'b0;
        cmd = CMD_ENQ;
        value = '0;
        cfg_valid = 1'b0;
        cfg_data = CAP_RESET;
        send_burst = 1'b0;
        filling = 1'b0;
        run_left = 0;
        cap_settings = 0;
        foreach (cmd_tally[i])
            cmd_tally[i] = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty ring: failed dequeue, failed search, unused code
        send_command(CMD_DEQ, '0);
        send_command(CMD_SRCH, '0);
        send_command(CMD_NOP, '0);
        // Fill every slot once, extremes first, then overflow
        send_command(CMD_ENQ, 32'h8000_0000);
        send_command(CMD_ENQ, 32'h7fff_ffff);
        send_command(CMD_ENQ, '1);
        send_command(CMD_ENQ, '0);
        for (int i = 0; i < 12; i++)
            send_command(CMD_ENQ, WORD_W'(32'h5a5a_0000 + i));
        send_command(CMD_ENQ, WORD_W'(123));
        // Search hits at head and at tail, a miss, unused code when full
        send_command(CMD_SRCH, 32'h8000_0000);
        send_command(CMD_SRCH, 32'h5a5a_000b);
        send_command(CMD_SRCH, 32'h1234_5678);
        send_command(CMD_NOP, '1);
        send_command(CMD_DEQ, '1);
        send_command(CMD_SRCH, '1);
        drain_replies();

        // Random phases; entries stay held across capacity changes
        foreach (capacity_plan[p]) begin
            write_capacity(capacity_plan[p]);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (run_left == 0) begin
                    filling = !filling;
                    run_left = $urandom_range(10, 40);
                end
                run_left--;
                send_command(pick_command(filling), pick_word());
                if (p == 4 && i == PHASE_ITEMS / 2)
                    drain_replies();
            end
            drain_replies();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d enqueue, %0d dequeue, %0d search and %0d unused-code commands",
                 cmd_tally[CMD_ENQ], cmd_tally[CMD_DEQ], cmd_tally[CMD_SRCH], cmd_tally[CMD_NOP]);
        $display("Wrote capacity %0d times, covering 0, 1, 16, 31 with entries held",
                 cap_settings);
        if (mismatches == 0 && pending == 0)
            $display("circular_fifo_with_search test passed");
        else
            $display("circular_fifo_with_search test failed");
        $finish;
    end

endmodule

/* files.f */
rtl/core/cfws_pkg.sv
rtl/core/cfws_ram.sv
rtl/core/circular_fifo_with_search.sv
sim/circular_fifo_with_search_checker.sv
sim/circular_fifo_with_search_tb.sv
